>>> sv/gfe_pkg.sv
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared types and constants for the Gaussian forward elimination unit.
// ----------------------------------------------------------------------------
package gfe_pkg;

	localparam int MAX_ORDER   = 8;
	localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int IDX_W       = $clog2(MAX_ORDER);
	localparam int ORD_W       = 4;
	localparam int CNT_W       = ADDR_W + 1;

	localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
	localparam logic [31:0] FP_ZERO     = 32'h0000_0000;
	localparam logic [31:0] FP_NAN_DEF  = 32'hFFC0_0000;
	localparam logic [31:0] FP_NAN_POS  = 32'h7FC0_0000;
	localparam logic [31:0] FP_QUIET    = 32'h0040_0000;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_SUB,
		OP_DIV
	} gfe_op_t;

	typedef struct packed {
		logic        go;
		gfe_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} gfe_fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] res;
	} gfe_fpu_rsp_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_NORM_A,
		F_NORM_B,
		F_CORE,
		F_ADD,
		F_DIV,
		F_NORM,
		F_DENORM,
		F_ROUND
	} gfe_fpu_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PIV_RD,
		ST_PIV_LD,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_WT,
		ST_ONE,
		ST_FAC_RD,
		ST_FAC_LD,
		ST_PRV_RD,
		ST_MUL_GO,
		ST_MUL_WT,
		ST_ROW_RD,
		ST_SUB_GO,
		ST_SUB_WT,
		ST_ZERO,
		ST_OUT
	} gfe_state_t;

endpackage

>>> sv/gfe_fpu.sv
// ----------------------------------------------------------------------------
// gfe_fpu
// Shared iterative binary32 unit: multiply, subtract and divide, round to
// nearest even, with subnormals; one shift or division step per cycle.
// ----------------------------------------------------------------------------
module gfe_fpu
	import gfe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  gfe_fpu_req_t req,
	output gfe_fpu_rsp_t rsp
);

	gfe_fpu_state_t state_q, state_d;
	logic           done_q;
	logic [31:0]    res_q;

	gfe_op_t            op_q;
	logic               sa_q, sb_q, sign_q, effsub_q, sticky_q;
	logic signed [11:0] ea_q, eb_q, exp_q;
	logic [23:0]        ma_q, mb_q;
	logic [49:0]        mant_q, yal_q;
	logic [24:0]        rem_q;
	logic [26:0]        quo_q;
	logic [4:0]         cnt_q;

	// unpack and special operands
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
	logic        spec;
	logic [31:0] spec_val;

	always_comb begin
		a_nan  = (req.a[30:23] == 8'hFF) && (req.a[22:0] != 23'd0);
		b_nan  = (req.b[30:23] == 8'hFF) && (req.b[22:0] != 23'd0);
		a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
		b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
		a_zero = (req.a[30:0] == 31'd0);
		b_zero = (req.b[30:0] == 31'd0);
		sx     = req.a[31] ^ req.b[31];
		spec     = 1'b1;
		spec_val = FP_ZERO;
		case (req.op)
			OP_MUL: begin
				if (a_nan)
					spec_val = req.a | FP_QUIET;
				else if (b_nan)
					spec_val = req.b | FP_QUIET;
				else if ((a_inf && b_zero) || (a_zero && b_inf))
					spec_val = FP_NAN_DEF;
				else if (a_inf || b_inf)
					spec_val = {sx, 8'hFF, 23'd0};
				else if (a_zero || b_zero)
					spec_val = {sx, 31'd0};
				else
					spec = 1'b0;
			end
			OP_SUB: begin
				if (a_nan)
					spec_val = req.a | FP_QUIET;
				else if (b_nan)
					spec_val = req.b | FP_QUIET;
				else if (a_inf && b_inf && (req.a[31] == req.b[31]))
					spec_val = FP_NAN_DEF;
				else if (a_inf)
					spec_val = req.a;
				else if (b_inf)
					spec_val = {~req.b[31], req.b[30:0]};
				else if (a_zero && b_zero)
					spec_val = {req.a[31] & ~req.b[31], 31'd0};
				else if (a_zero)
					spec_val = {~req.b[31], req.b[30:0]};
				else if (b_zero)
					spec_val = req.a;
				else
					spec = 1'b0;
			end
			OP_DIV: begin
				if (b_zero) begin
					if (a_nan)
						spec_val = req.a | FP_QUIET;
					else if (a_zero)
						spec_val = FP_NAN_POS;
					else
						spec_val = {sx, 8'hFF, 23'd0};
				end else if (a_nan)
					spec_val = req.a | FP_QUIET;
				else if (b_nan)
					spec_val = req.b | FP_QUIET;
				else if (a_inf && b_inf)
					spec_val = FP_NAN_DEF;
				else if (a_inf)
					spec_val = {sx, 8'hFF, 23'd0};
				else if (b_inf || a_zero)
					spec_val = {sx, 31'd0};
				else
					spec = 1'b0;
			end
			default: spec_val = FP_NAN_DEF;
		endcase
	end

	// subtract alignment
	logic               a_big, x_s;
	logic [23:0]        mx, my;
	logic signed [11:0] ex, ediff;
	logic [49:0]        xw, yw, ysh, ymask, yal;

	always_comb begin
		a_big = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
		mx    = a_big ? ma_q : mb_q;
		my    = a_big ? mb_q : ma_q;
		ex    = a_big ? ea_q : eb_q;
		x_s   = a_big ? sa_q : ~sb_q;
		ediff = a_big ? (ea_q - eb_q) : (eb_q - ea_q);
		xw    = {1'b0, mx, 25'd0};
		yw    = {1'b0, my, 25'd0};
		ysh   = yw >> ediff[5:0];
		ymask = (50'd1 << ediff[5:0]) - 50'd1;
		if (ediff >= 12'sd50)
			yal = 50'd1;
		else
			yal = ysh | {49'd0, |(yw & ymask)};
	end

	logic [49:0] sum;
	assign sum = effsub_q ? (mant_q - yal_q) : (mant_q + yal_q);

	logic [47:0] prod;
	assign prod = ma_q * mb_q;

	// one restoring division step
	logic        div_ge;
	logic [24:0] rdiff;
	logic [26:0] quo_nx;

	always_comb begin
		div_ge = rem_q >= {1'b0, mb_q};
		rdiff  = div_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
		quo_nx = {quo_q[25:0], div_ge};
	end

	// rounding
	logic               rnd_st, rnd_up;
	logic [24:0]        r25;
	logic [23:0]        r24;
	logic signed [11:0] e_fin;
	logic [31:0]        rnd_val;

	always_comb begin
		rnd_st = (|mant_q[24:0]) | sticky_q;
		rnd_up = mant_q[25] & (mant_q[26] | rnd_st);
		r25    = {1'b0, mant_q[49:26]} + {24'd0, rnd_up};
		e_fin  = r25[24] ? (exp_q + 12'sd1) : exp_q;
		r24    = r25[24] ? 24'h80_0000 : r25[23:0];
		if (e_fin >= 12'sd255)
			rnd_val = {sign_q, 8'hFF, 23'd0};
		else
			rnd_val = {sign_q, (r24[23] ? e_fin[7:0] : 8'd0), r24[22:0]};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:   if (req.go && !spec) state_d = F_NORM_A;
			F_NORM_A: if (ma_q[23]) state_d = F_NORM_B;
			F_NORM_B: if (mb_q[23]) state_d = F_CORE;
			F_CORE: begin
				case (op_q)
					OP_SUB:  state_d = F_ADD;
					OP_DIV:  state_d = F_DIV;
					default: state_d = F_NORM;
				endcase
			end
			F_ADD:    state_d = (sum == 50'd0) ? F_IDLE : F_NORM;
			F_DIV:    if (cnt_q == 5'd0) state_d = F_NORM;
			F_NORM:   if (mant_q[49]) state_d = F_DENORM;
			F_DENORM: if (exp_q >= 12'sd1) state_d = F_ROUND;
			F_ROUND:  state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == F_IDLE) && req.go && spec)
				|| ((state_q == F_ADD) && (sum == 50'd0))
				|| (state_q == F_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.go) begin
					op_q     <= req.op;
					res_q    <= spec_val;
					sa_q     <= req.a[31];
					sb_q     <= req.b[31];
					ma_q     <= {req.a[30:23] != 8'd0, req.a[22:0]};
					mb_q     <= {req.b[30:23] != 8'd0, req.b[22:0]};
					ea_q     <= (req.a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, req.a[30:23]});
					eb_q     <= (req.b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, req.b[30:23]});
					sticky_q <= 1'b0;
				end
			end
			F_NORM_A: begin
				if (!ma_q[23]) begin
					ma_q <= {ma_q[22:0], 1'b0};
					ea_q <= ea_q - 12'sd1;
				end
			end
			F_NORM_B: begin
				if (!mb_q[23]) begin
					mb_q <= {mb_q[22:0], 1'b0};
					eb_q <= eb_q - 12'sd1;
				end
			end
			F_CORE: begin
				case (op_q)
					OP_SUB: begin
						mant_q   <= xw;
						yal_q    <= yal;
						exp_q    <= ex + 12'sd1;
						sign_q   <= x_s;
						effsub_q <= (sa_q == sb_q);
					end
					OP_DIV: begin
						rem_q  <= {1'b0, ma_q};
						quo_q  <= 27'd0;
						cnt_q  <= 5'd26;
						exp_q  <= ea_q - eb_q + 12'sd127;
						sign_q <= sa_q ^ sb_q;
					end
					default: begin
						mant_q <= {2'b00, prod};
						exp_q  <= ea_q + eb_q - 12'sd124;
						sign_q <= sa_q ^ sb_q;
					end
				endcase
			end
			F_ADD: begin
				mant_q <= sum;
				res_q  <= FP_ZERO;
			end
			F_DIV: begin
				quo_q <= quo_nx;
				rem_q <= {rdiff[23:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					mant_q   <= {quo_nx, 23'd0};
					sticky_q <= (rdiff != 25'd0);
				end
			end
			F_NORM: begin
				if (!mant_q[49]) begin
					mant_q <= {mant_q[48:0], 1'b0};
					exp_q  <= exp_q - 12'sd1;
				end
			end
			F_DENORM: begin
				if (exp_q < -12'sd60) begin
					sticky_q <= sticky_q | (|mant_q);
					mant_q   <= 50'd0;
					exp_q    <= 12'sd1;
				end else if (exp_q < 12'sd1) begin
					sticky_q <= sticky_q | mant_q[0];
					mant_q   <= {1'b0, mant_q[49:1]};
					exp_q    <= exp_q + 12'sd1;
				end
			end
			F_ROUND: res_q <= rnd_val;
			default: res_q <= res_q;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

>>> sv/gaussian_forward_elimination_unit.sv
// ----------------------------------------------------------------------------
// gaussian_forward_elimination_unit
// Forward elimination without pivoting on a square binary32 matrix.
// ----------------------------------------------------------------------------
// usage
//   load: element_bits is taken at a clock edge with start high and busy low,
//   row-major, n*n transactions, n from cfg_wr_data clamped to 2..8; busy
//   stays low while loading, so elements may follow every cycle.
//   a write on cfg_wr_en sets n and drops a partly loaded matrix.
//   after the last element busy rises; elimination runs on one shared
//   iterative binary32 unit, one multiply, subtract or divide at a time.
//   a subtract that cancels exactly skips normalising and rounding, and every
//   normalising or denormalising shift is a step of its own in that unit.
//   for n = 8 elimination takes 28 divides and 140 multiply-subtracts.
//   results then leave one per cycle on result_bits, result_valid high for each
//   of the n*n results, result_last on the final one; the receiver cannot stall.
//   busy falls together with the last result cycle.
//   reset sets n to 8, clears the load count and returns to idle; the
//   matrix store is not cleared.
// ----------------------------------------------------------------------------
module gaussian_forward_elimination_unit
	import gfe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] element_bits,
	output logic        result_valid,
	output logic [31:0] result_bits,
	output logic        result_last
);

	gfe_state_t state_q, state_d;

	logic [ORD_W-1:0]  order_q, n_eff;
	logic [CNT_W-1:0]  lc_q, total;
	logic [IDX_W-1:0]  k_q, i_q, j_q;
	logic [ADDR_W-1:0] out_q;
	logic              rv_q, rl_q;
	logic [31:0]       pivot_q, factor_q, prod_q, rdata_q;
	logic [31:0]       mem [STORE_DEPTH];

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [31:0]       mem_wdata;

	gfe_fpu_req_t fpu_req;
	gfe_fpu_rsp_t fpu_rsp;

	gfe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [ORD_W-1:0] n);
		logic [CNT_W-1:0] p;
		p = CNT_W'(r) * CNT_W'(n) + CNT_W'(c);
		return p[ADDR_W-1:0];
	endfunction

	always_comb begin
		if (order_q < ORD_W'(2))
			n_eff = ORD_W'(2);
		else if (order_q > ORD_W'(MAX_ORDER))
			n_eff = ORD_W'(MAX_ORDER);
		else
			n_eff = order_q;
		total = CNT_W'(n_eff) * CNT_W'(n_eff);
	end

	logic j_more, i_more, k_more, accept, load_end, out_end;

	always_comb begin
		j_more   = (ORD_W'(j_q) + ORD_W'(1)) < n_eff;
		i_more   = (ORD_W'(i_q) + ORD_W'(1)) < n_eff;
		k_more   = (ORD_W'(k_q) + ORD_W'(1)) < n_eff;
		accept   = start && (state_q == ST_IDLE);
		load_end = (lc_q + CNT_W'(1)) == total;
		out_end  = (CNT_W'(out_q) + CNT_W'(1)) == total;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && load_end) state_d = ST_PIV_RD;
			ST_PIV_RD: state_d = ST_PIV_LD;
			ST_PIV_LD: state_d = k_more ? ST_DIV_RD : ST_ONE;
			ST_DIV_RD: state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV_WT;
			ST_DIV_WT: if (fpu_rsp.done) state_d = j_more ? ST_DIV_RD : ST_ONE;
			ST_ONE:    state_d = k_more ? ST_FAC_RD : ST_OUT;
			ST_FAC_RD: state_d = ST_FAC_LD;
			ST_FAC_LD: state_d = ST_PRV_RD;
			ST_PRV_RD: state_d = ST_MUL_GO;
			ST_MUL_GO: state_d = ST_MUL_WT;
			ST_MUL_WT: if (fpu_rsp.done) state_d = ST_ROW_RD;
			ST_ROW_RD: state_d = ST_SUB_GO;
			ST_SUB_GO: state_d = ST_SUB_WT;
			ST_SUB_WT: if (fpu_rsp.done) state_d = j_more ? ST_PRV_RD : ST_ZERO;
			ST_ZERO:   state_d = i_more ? ST_FAC_RD : ST_PIV_RD;
			ST_OUT:    if (out_end) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = elem_addr(i_q, j_q, n_eff);
		mem_wdata   = fpu_rsp.res;
		mem_raddr   = elem_addr(k_q, j_q, n_eff);
		fpu_req.go  = 1'b0;
		fpu_req.op  = OP_MUL;
		fpu_req.a   = rdata_q;
		fpu_req.b   = prod_q;
		case (state_q)
			ST_IDLE: begin
				mem_we    = accept;
				mem_waddr = lc_q[ADDR_W-1:0];
				mem_wdata = element_bits;
			end
			ST_PIV_RD: mem_raddr = elem_addr(k_q, k_q, n_eff);
			ST_DIV_GO: begin
				fpu_req.go = 1'b1;
				fpu_req.op = OP_DIV;
				fpu_req.b  = pivot_q;
			end
			ST_DIV_WT: begin
				mem_we    = fpu_rsp.done;
				mem_waddr = elem_addr(k_q, j_q, n_eff);
			end
			ST_ONE: begin
				mem_we    = 1'b1;
				mem_waddr = elem_addr(k_q, k_q, n_eff);
				mem_wdata = FP_ONE;
			end
			ST_FAC_RD: mem_raddr = elem_addr(i_q, k_q, n_eff);
			ST_MUL_GO: begin
				fpu_req.go = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = factor_q;
				fpu_req.b  = rdata_q;
			end
			ST_ROW_RD: mem_raddr = elem_addr(i_q, j_q, n_eff);
			ST_SUB_GO: begin
				fpu_req.go = 1'b1;
				fpu_req.op = OP_SUB;
			end
			ST_SUB_WT: mem_we = fpu_rsp.done;
			ST_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = elem_addr(i_q, k_q, n_eff);
				mem_wdata = FP_ZERO;
			end
			ST_OUT: mem_raddr = out_q;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PIV_LD)
			pivot_q <= rdata_q;
		if (state_q == ST_FAC_LD)
			factor_q <= rdata_q;
		if ((state_q == ST_MUL_WT) && fpu_rsp.done)
			prod_q <= fpu_rsp.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			order_q <= ORD_W'(MAX_ORDER);
			lc_q    <= '0;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			out_q   <= '0;
			rv_q    <= 1'b0;
			rl_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= (state_q == ST_OUT);
			rl_q    <= (state_q == ST_OUT) && out_end;
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
				lc_q    <= '0;
			end else if (accept) begin
				lc_q <= load_end ? '0 : (lc_q + CNT_W'(1));
				k_q  <= '0;
			end
			case (state_q)
				ST_PIV_LD: j_q <= k_q + IDX_W'(1);
				ST_DIV_WT: if (fpu_rsp.done) j_q <= j_q + IDX_W'(1);
				ST_ONE: begin
					i_q   <= k_q + IDX_W'(1);
					out_q <= '0;
				end
				ST_FAC_LD: j_q <= k_q + IDX_W'(1);
				ST_SUB_WT: if (fpu_rsp.done) j_q <= j_q + IDX_W'(1);
				ST_ZERO: begin
					i_q <= i_q + IDX_W'(1);
					if (!i_more)
						k_q <= k_q + IDX_W'(1);
				end
				ST_OUT: out_q <= out_q + ADDR_W'(1);
				default: out_q <= out_q;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = rv_q;
	assign result_last  = rl_q;
	assign result_bits  = rdata_q;

endmodule
